[hw/rtl/polygon_ear_clip_triangulator_macros.svh]
// Assertion macros for the polygon ear-clip triangulator.
// Used by the top level; needs clk and rst in the calling scope.
`ifndef POLYGON_EAR_CLIP_TRIANGULATOR_MACROS_SVH
`define POLYGON_EAR_CLIP_TRIANGULATOR_MACROS_SVH

// same-cycle implication
`define PECT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pect assertion failed");

// next-cycle implication
`define PECT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pect assertion failed");

`endif

[hw/rtl/pect_pkg.sv]
// Shared types for the polygon ear-clip triangulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pect_pkg;

  // write enables of the two link arrays
  typedef struct packed {
    logic next_we;
    logic prev_we;
  } link_we_t;

endpackage
`default_nettype wire

[hw/rtl/pect_coord_mem.sv]
// Vertex coordinate store: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module pect_coord_mem #(
  parameter int DEPTH = 64,
  parameter int IW = 6,
  parameter int CB = 20
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IW-1:0]        waddr,
  input  wire logic signed [CB-1:0] wx,
  input  wire logic signed [CB-1:0] wy,
  input  wire logic [IW-1:0]        raddr,
  output logic signed [CB-1:0]      rx,
  output logic signed [CB-1:0]      ry
);

  logic [2*CB-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wx, wy};
    end
    rx <= mem[raddr][2*CB-1:CB];
    ry <= mem[raddr][CB-1:0];
  end

endmodule
`default_nettype wire

[hw/rtl/pect_link_mem.sv]
// Ring link store: next and prev arrays, one write each, shared registered read.
// Depends on pect_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pect_link_mem #(
  parameter int DEPTH = 64,
  parameter int IW = 6
) (
  input  wire logic              clk,
  input  wire pect_pkg::link_we_t we,
  input  wire logic [IW-1:0]     next_addr,
  input  wire logic [IW-1:0]     next_data,
  input  wire logic [IW-1:0]     prev_addr,
  input  wire logic [IW-1:0]     prev_data,
  input  wire logic [IW-1:0]     raddr,
  output logic [IW-1:0]          rnext,
  output logic [IW-1:0]          rprev
);

  logic [IW-1:0] next_mem [DEPTH];
  logic [IW-1:0] prev_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.next_we) begin
      next_mem[next_addr] <= next_data;
    end
    if (we.prev_we) begin
      prev_mem[prev_addr] <= prev_data;
    end
    rnext <= next_mem[raddr];
    rprev <= prev_mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/pect_cross.sv]
// Exact cross product sign of (u - o) x (v - o), products registered.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module pect_cross #(
  parameter int CB = 20
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CB-1:0] ox,
  input  wire logic signed [CB-1:0] oy,
  input  wire logic signed [CB-1:0] ux,
  input  wire logic signed [CB-1:0] uy,
  input  wire logic signed [CB-1:0] vx,
  input  wire logic signed [CB-1:0] vy,
  output logic                      gt,
  output logic                      lt
);

  logic signed [CB:0]     dux, duy, dvx, dvy;
  logic signed [2*CB+1:0] p1, p2;

  assign dux = (CB+1)'(ux) - (CB+1)'(ox);
  assign duy = (CB+1)'(uy) - (CB+1)'(oy);
  assign dvx = (CB+1)'(vx) - (CB+1)'(ox);
  assign dvy = (CB+1)'(vy) - (CB+1)'(oy);

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= dux * dvy;
      p2 <= duy * dvx;
    end
  end

  assign gt = p1 > p2;
  assign lt = p1 < p2;

endmodule
`default_nettype wire

[hw/rtl/polygon_ear_clip_triangulator.sv]
// Polygon ear-clip triangulator top level: load sequencer and clipping FSM.
// Depends on pect_pkg, pect_coord_mem, pect_link_mem, pect_cross and the macro header.
//
// Usage: present one vertex per transaction on x_coord/y_coord with start high;
// it is taken at an edge where start is high and busy is low. index_base is
// latched on the first vertex of a polygon. Loading takes any such vertex
// and busy stays low. The vertex with last_vertex set starts clipping when the
// polygon holds three or more vertices; busy then stays high until the final
// triangle has been issued. Each triangle appears for one cycle with valid
// high; the receiver must take it then, there is no stall. Vertices beyond
// MAX_VERTICES are dropped and every triangle of that polygon flags truncated.
// Sequence: the ring links are built first; each ear test then reads the corner
// and its two neighbours and runs the convexity test; a convex corner then walks
// the rest of the ring, skipping vertices that coincide with a corner and giving
// each other one three cross-product tests. The pace is set by the single read
// port of the coordinate store and the one shared cross-product unit.
// Reset (rst, synchronous) clears the load count and returns to idle; the
// stores need no clearing since only loaded entries are read.
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_ear_clip_triangulator_macros.svh"
module polygon_ear_clip_triangulator #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS = 20
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  input  wire logic [31:0]                  index_base,
  input  wire logic                         last_vertex,
  output logic                              valid,
  output logic [31:0]                       idx_a,
  output logic [31:0]                       idx_b,
  output logic [31:0]                       idx_c,
  output logic                              forced_cut,
  output logic                              truncated,
  output logic                              last_triangle
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int CB = COORD_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LINK = 4'd1;
  localparam logic [3:0] S_RD_I = 4'd2;
  localparam logic [3:0] S_GET_I = 4'd3;
  localparam logic [3:0] S_CA = 4'd4;
  localparam logic [3:0] S_CI = 4'd5;
  localparam logic [3:0] S_CC = 4'd6;
  localparam logic [3:0] S_MUL = 4'd7;
  localparam logic [3:0] S_EVAL = 4'd8;
  localparam logic [3:0] S_JN = 4'd9;
  localparam logic [3:0] S_JCHK = 4'd10;
  localparam logic [3:0] S_JGET = 4'd11;

  localparam logic [1:0] OP_CONVEX = 2'd0;
  localparam logic [1:0] OP_D1 = 2'd1;
  localparam logic [1:0] OP_D2 = 2'd2;
  localparam logic [1:0] OP_D3 = 2'd3;

  logic [3:0]    state;
  logic [CW-1:0] count, count_next, n;
  logic          ovf, ovf_next, trunc;
  logic [31:0]   base;
  logic [IW-1:0] k, cursor, a_pos, c_pos, j;
  logic [CW-1:0] left;
  logic [CW:0]   miss, miss_next;
  logic          forced_pend;
  logic [1:0]    op;
  logic          neg, pos, neg_all, pos_all;
  logic signed [CB-1:0] ax, ay, bx, by, cx, cy, px, py;

  logic          accept, fits;
  logic [IW-1:0] crd_addr, lrd_addr, l_next, l_prev;
  logic signed [CB-1:0] rx, ry;
  pect_pkg::link_we_t lwe;
  logic [IW-1:0] nw_addr, nw_data, pw_addr, pw_data;
  logic          cut, cut_forced, cut_last;
  logic [IW-1:0] cut_a, cut_c;
  logic signed [CB-1:0] ox, oy, ux, uy, vx, vy;
  logic          cr_gt, cr_lt, same;

  assign busy = state != S_IDLE;
  assign accept = start && !busy;
  assign fits = count < CW'(MAX_VERTICES);
  assign count_next = fits ? count + CW'(1) : count;
  assign ovf_next = ovf || !fits;
  assign miss_next = miss + (CW+1)'(1);
  assign neg_all = neg || cr_lt;
  assign pos_all = pos || cr_gt;
  assign same = (rx == ax && ry == ay) || (rx == bx && ry == by) || (rx == cx && ry == cy);

  pect_coord_mem #(.DEPTH(MAX_VERTICES), .IW(IW), .CB(CB)) u_coord (
    .clk(clk), .we(accept && fits), .waddr(count[IW-1:0]),
    .wx(x_coord), .wy(y_coord), .raddr(crd_addr), .rx(rx), .ry(ry)
  );

  pect_link_mem #(.DEPTH(MAX_VERTICES), .IW(IW)) u_link (
    .clk(clk), .we(lwe), .next_addr(nw_addr), .next_data(nw_data),
    .prev_addr(pw_addr), .prev_data(pw_data), .raddr(lrd_addr),
    .rnext(l_next), .rprev(l_prev)
  );

  pect_cross #(.CB(CB)) u_cross (
    .clk(clk), .en(state == S_MUL), .ox(ox), .oy(oy), .ux(ux), .uy(uy),
    .vx(vx), .vy(vy), .gt(cr_gt), .lt(cr_lt)
  );

  // read addresses
  always_comb begin
    case (state)
      S_GET_I: crd_addr = l_prev;
      S_CI:    crd_addr = c_pos;
      S_JCHK:  crd_addr = j;
      default: crd_addr = cursor;
    endcase
    case (state)
      S_EVAL:  lrd_addr = c_pos;
      S_JCHK:  lrd_addr = j;
      default: lrd_addr = cursor;
    endcase
  end

  // cross operand select
  always_comb begin
    case (op)
      OP_CONVEX: begin ox = ax; oy = ay; ux = bx; uy = by; vx = cx; vy = cy; end
      OP_D1:     begin ox = ax; oy = ay; ux = bx; uy = by; vx = px; vy = py; end
      OP_D2:     begin ox = bx; oy = by; ux = cx; uy = cy; vx = px; vy = py; end
      default:   begin ox = cx; oy = cy; ux = ax; uy = ay; vx = px; vy = py; end
    endcase
  end

  // cut decision and link writes; every cut passes through S_RD_I before the next link read
  always_comb begin
    cut = 1'b0;
    cut_forced = 1'b0;
    cut_last = 1'b0;
    cut_a = a_pos;
    cut_c = c_pos;
    if (state == S_GET_I) begin
      cut_a = l_prev;
      cut_c = l_next;
      if (forced_pend) begin
        cut = 1'b1;
        cut_forced = 1'b1;
      end else if (left <= CW'(3)) begin
        cut = 1'b1;
        cut_last = 1'b1;
      end
    end else if (state == S_JCHK && j == a_pos) begin
      cut = 1'b1;
    end
    lwe = '{next_we: 1'b0, prev_we: 1'b0};
    nw_addr = cut_a;
    nw_data = cut_c;
    pw_addr = cut_c;
    pw_data = cut_a;
    if (state == S_LINK) begin
      lwe = '{next_we: 1'b1, prev_we: 1'b1};
      nw_addr = k;
      pw_addr = k;
      nw_data = (CW'(k) == n - CW'(1)) ? '0 : k + IW'(1);
      pw_data = (k == '0) ? IW'(n - CW'(1)) : k - IW'(1);
    end else if (cut && !cut_last) begin
      lwe = '{next_we: 1'b1, prev_we: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf <= 1'b0;
      base <= '0;
      valid <= 1'b0;
      forced_pend <= 1'b0;
      left <= '0;
      miss <= '0;
      cursor <= '0;
    end else begin
      valid <= cut;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (count == '0 && !ovf) begin
              base <= index_base;
            end
            // a marked last vertex closes the polygon and rearms the load
            count <= last_vertex ? '0 : count_next;
            ovf <= last_vertex ? 1'b0 : ovf_next;
            if (last_vertex && count_next >= CW'(3)) begin
              n <= count_next;
              trunc <= ovf_next;
              k <= '0;
              state <= S_LINK;
            end
          end
        end
        S_LINK: begin
          k <= k + IW'(1);
          if (CW'(k) == n - CW'(1)) begin
            left <= n;
            cursor <= '0;
            miss <= '0;
            forced_pend <= 1'b0;
            state <= S_RD_I;
          end
        end
        S_RD_I: state <= S_GET_I;
        S_GET_I: begin
          a_pos <= l_prev;
          c_pos <= l_next;
          if (!cut) begin
            state <= S_CA;
          end
        end
        S_CA: begin
          ax <= rx;
          ay <= ry;
          state <= S_CI;
        end
        S_CI: begin
          bx <= rx;
          by <= ry;
          state <= S_CC;
        end
        S_CC: begin
          cx <= rx;
          cy <= ry;
          op <= OP_CONVEX;
          state <= S_MUL;
        end
        S_MUL: state <= S_EVAL;
        S_EVAL: begin
          neg <= neg_all;
          pos <= pos_all;
          if ((op == OP_CONVEX && !cr_gt) || (op == OP_D3 && !(neg_all && pos_all))) begin
            // not an ear: advance and force a cut after a full lap
            cursor <= c_pos;
            miss <= miss_next;
            forced_pend <= miss_next > (CW+1)'(left);
            state <= S_RD_I;
          end else if (op == OP_CONVEX) begin
            state <= S_JN;
          end else if (op == OP_D3) begin
            j <= k;
            state <= S_JCHK;
          end else begin
            op <= op + 2'd1;
            state <= S_MUL;
          end
        end
        S_JN: begin
          j <= l_next;
          state <= S_JCHK;
        end
        S_JCHK: begin
          if (!cut) begin
            state <= S_JGET;
          end
        end
        S_JGET: begin
          px <= rx;
          py <= ry;
          k <= l_next;
          if (same) begin
            j <= l_next;
            state <= S_JCHK;
          end else begin
            neg <= 1'b0;
            pos <= 1'b0;
            op <= OP_D1;
            state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cut) begin
        idx_a <= base + 32'(cut_a);
        idx_b <= base + 32'(cursor);
        idx_c <= base + 32'(cut_c);
        forced_cut <= cut_forced;
        last_triangle <= cut_last;
        truncated <= trunc;
        cursor <= cut_c;
        left <= left - CW'(1);
        miss <= '0;
        forced_pend <= 1'b0;
        state <= cut_last ? S_IDLE : S_RD_I;
      end
    end
  end

  `PECT_ASSERT_IMPL(a_last_ends_busy, valid && last_triangle, !busy)
  `PECT_ASSERT_IMPL(a_forced_not_last, valid, !(forced_cut && last_triangle))
  `PECT_ASSERT_NEXT(a_strobe_gap, valid, !valid)
  `PECT_ASSERT_IMPL(a_left_floor, state != S_IDLE && state != S_LINK, left >= CW'(3))

endmodule
`default_nettype wire
